// ===== rtl/fpe_pkg.sv =====
package fpe_pkg;

    localparam int C_NROM  = 25;
    localparam int C_NSTEP = 5;

    localparam logic [14:0] C_K       = 15'd10000;
    localparam logic [4:0]  C_MAX_INT = 5'd24;
    localparam logic [31:0] C_SAT_X   = 32'd250000;
    localparam logic [63:0] C_TWO32   = 64'h1_0000_0000;

    // rounded-up reciprocal of 10000, exact quotient for x below 250000
    localparam logic [18:0] C_NREC   = 19'((C_TWO32 + 64'd9999) / 64'd10000);
    // rounded-up 2^16/6, exact for r below 10000
    localparam logic [13:0] C_SIXREC = 14'd10923;

    localparam logic [15:0] C_DIV  = 16'd9999;
    localparam logic [18:0] C_DREC = 19'(C_TWO32 / 64'd9999);

    typedef logic [47:0] t_rom_v [C_NROM];
    typedef logic [34:0] t_rom_q [C_NROM];
    typedef logic [13:0] t_rom_r [C_NROM];

    localparam t_rom_v C_EXP_ROM = '{
        48'd10000, 48'd27183, 48'd73891, 48'd200855, 48'd545982,
        48'd1484132, 48'd4034288, 48'd10966332, 48'd29809580, 48'd81030839,
        48'd220264658, 48'd598741417, 48'd1627547914, 48'd4424133920,
        48'd12026042842, 48'd32690173725, 48'd88861105205, 48'd241549527536,
        48'd656599691373, 48'd1784823009632, 48'd4851651954098,
        48'd13188157344832, 48'd35849128461316, 48'd97448034462489,
        48'd264891221298435
    };

    // table entry split as Q*9999 + R so the final divide only sees R*a1
    function automatic t_rom_q f_build_q();
        t_rom_q t;
        for (int i = 0; i < C_NROM; i++) begin
            t[i] = 35'(C_EXP_ROM[i] / 48'd9999);
        end
        return t;
    endfunction

    function automatic t_rom_r f_build_r();
        t_rom_r t;
        for (int i = 0; i < C_NROM; i++) begin
            t[i] = 14'(C_EXP_ROM[i] % 48'd9999);
        end
        return t;
    endfunction

    localparam t_rom_q C_ROM_Q = f_build_q();
    localparam t_rom_r C_ROM_R = f_build_r();

    localparam logic [49:0] C_SAT_OUT = 50'(C_EXP_ROM[C_NROM-1]);

    // Horner divisors i*10000 for i = 5..1
    typedef logic [15:0] t_hdiv [C_NSTEP];
    typedef logic [18:0] t_hrec [C_NSTEP];

    localparam t_hdiv C_HDIV = '{16'd50000, 16'd40000, 16'd30000, 16'd20000, 16'd10000};
    localparam t_hrec C_HREC = '{
        19'(C_TWO32 / 64'd50000), 19'(C_TWO32 / 64'd40000), 19'(C_TWO32 / 64'd30000),
        19'(C_TWO32 / 64'd20000), 19'(C_TWO32 / 64'd10000)
    };

    typedef struct packed {
        logic [4:0]  n;
        logic [13:0] r;
        logic        sat;
    } t_split;

    typedef struct packed {
        logic [4:0]  n;
        logic [14:0] a1;
        logic        sat;
    } t_poly;

    // reciprocal estimate q0 is q or q-1; one compare fixes it
    function automatic logic [14:0] f_qfix(input logic [28:0] p, input logic [14:0] q0,
                                           input logic [15:0] d);
        logic [28:0] rem;
        rem = p - 29'(q0) * 29'(d);
        return (rem >= 29'(d)) ? q0 + 15'd1 : q0;
    endfunction

endpackage

// ===== rtl/fpe_split.sv =====
module fpe_split
    import fpe_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [31:0] i_x,
    output logic        o_valid,
    input  logic        i_ready,
    output t_split      o_data
);

    localparam int NS = 2;

    logic [NS-1:0] r_v;
    logic [NS:0]   en;
    logic          r_sat0;
    logic [17:0]   r_x;
    logic [36:0]   r_np;
    t_split        r_o;
    logic [4:0]    w_n;

    always_comb begin
        en[NS] = i_ready;
        for (int k = NS - 1; k >= 0; k--) begin
            en[k] = !r_v[k] || en[k+1];
        end
    end

    assign o_ready = en[0];
    assign o_valid = r_v[NS-1];
    assign o_data  = r_o;
    assign w_n     = r_np[36:32];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (en[0]) r_v[0] <= i_valid;
            if (en[1]) r_v[1] <= r_v[0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[0] && i_valid) begin
            r_sat0 <= (i_x >= C_SAT_X);
            r_x    <= i_x[17:0];
            r_np   <= 37'(i_x[17:0]) * 37'(C_NREC);
        end
        if (en[1] && r_v[0]) begin
            r_o.n   <= r_sat0 ? C_MAX_INT : w_n;
            r_o.r   <= 14'(r_x - 18'(w_n) * 18'(C_K));
            r_o.sat <= r_sat0;
        end
    end

    a_split_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[1] |-> (r_o.n <= C_MAX_INT) && (r_o.sat || r_o.r < 14'd10000))
        else $error("split produced out-of-range n or r");

endmodule

// ===== rtl/fpe_horner.sv =====
module fpe_horner
    import fpe_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_valid,
    output logic   o_ready,
    input  t_split i_data,
    output logic   o_valid,
    input  logic   i_ready,
    output t_poly  o_data
);

    // stage 0 forms a6, then each step has multiply, reciprocal, fix-up stages
    localparam int NS = 1 + 3 * C_NSTEP;

    logic [NS-1:0] r_v;
    logic [NS:0]   en;
    logic [13:0]   r_r   [NS];
    logic [4:0]    r_n   [NS];
    logic          r_sat [NS];
    logic [14:0]   r_a   [C_NSTEP+1];
    logic [28:0]   r_p   [C_NSTEP];
    logic [28:0]   r_pb  [C_NSTEP];
    logic [14:0]   r_q0  [C_NSTEP];

    always_comb begin
        en[NS] = i_ready;
        for (int k = NS - 1; k >= 0; k--) begin
            en[k] = !r_v[k] || en[k+1];
        end
    end

    assign o_ready    = en[0];
    assign o_valid    = r_v[NS-1];
    assign o_data.n   = r_n[NS-1];
    assign o_data.a1  = r_a[C_NSTEP];
    assign o_data.sat = r_sat[NS-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (en[0]) r_v[0] <= i_valid;
            for (int k = 1; k < NS; k++) begin
                if (en[k]) r_v[k] <= r_v[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[0] && i_valid) begin
            r_r[0]   <= i_data.r;
            r_n[0]   <= i_data.n;
            r_sat[0] <= i_data.sat;
            r_a[0]   <= C_K + 15'((28'(i_data.r) * 28'(C_SIXREC)) >> 16);
        end
        for (int k = 1; k < NS; k++) begin
            if (en[k] && r_v[k-1]) begin
                r_r[k]   <= r_r[k-1];
                r_n[k]   <= r_n[k-1];
                r_sat[k] <= r_sat[k-1];
            end
        end
        for (int j = 0; j < C_NSTEP; j++) begin
            if (en[3*j+1] && r_v[3*j]) begin
                r_p[j] <= 29'(r_r[3*j]) * 29'(r_a[j]);
            end
            if (en[3*j+2] && r_v[3*j+1]) begin
                r_pb[j] <= r_p[j];
                r_q0[j] <= 15'((48'(r_p[j]) * 48'(C_HREC[j])) >> 32);
            end
            if (en[3*j+3] && r_v[3*j+2]) begin
                r_a[j+1] <= C_K + f_qfix(r_pb[j], r_q0[j], C_HDIV[j]);
            end
        end
    end

    for (genvar g = 0; g < C_NSTEP; g++) begin : g_chk
        logic [28:0] w_qd;
        assign w_qd = 29'(r_q0[g]) * 29'(C_HDIV[g]);

        a_one_fix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
            r_v[3*g+2] |-> (w_qd <= r_pb[g]) &&
                           (r_pb[g] - w_qd < 29'(C_HDIV[g]) + 29'(C_HDIV[g])))
            else $error("reciprocal estimate off by more than one");
    end

endmodule

// ===== rtl/fpe_scale.sv =====
module fpe_scale
    import fpe_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  t_poly       i_data,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [49:0] o_exp
);

    localparam int NS = 4;

    logic [NS-1:0] r_v;
    logic [NS:0]   en;
    logic          r_sat [NS-1];
    logic [34:0]   r_q;
    logic [13:0]   r_rm;
    logic [14:0]   r_a1;
    logic [49:0]   r_hi;
    logic [49:0]   r_hi2;
    logic [28:0]   r_lo;
    logic [28:0]   r_lob;
    logic [14:0]   r_lq0;
    logic [49:0]   r_out;

    always_comb begin
        en[NS] = i_ready;
        for (int k = NS - 1; k >= 0; k--) begin
            en[k] = !r_v[k] || en[k+1];
        end
    end

    assign o_ready = en[0];
    assign o_valid = r_v[NS-1];
    assign o_exp   = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (en[0]) r_v[0] <= i_valid;
            for (int k = 1; k < NS; k++) begin
                if (en[k]) r_v[k] <= r_v[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[0] && i_valid) begin
            r_q      <= C_ROM_Q[i_data.n];
            r_rm     <= C_ROM_R[i_data.n];
            r_a1     <= i_data.a1;
            r_sat[0] <= i_data.sat;
        end
        if (en[1] && r_v[0]) begin
            r_hi     <= 50'(r_q) * 50'(r_a1);
            r_lo     <= 29'(r_rm) * 29'(r_a1);
            r_sat[1] <= r_sat[0];
        end
        if (en[2] && r_v[1]) begin
            r_hi2    <= r_hi;
            r_lob    <= r_lo;
            r_lq0    <= 15'((48'(r_lo) * 48'(C_DREC)) >> 32);
            r_sat[2] <= r_sat[1];
        end
        if (en[3] && r_v[2]) begin
            r_out <= r_sat[2] ? C_SAT_OUT : r_hi2 + 50'(f_qfix(r_lob, r_lq0, C_DIV));
        end
    end

    a_exp_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[NS-1] |-> (r_out >= 50'(C_K)))
        else $error("exponential result below one");

endmodule

// ===== rtl/fixed_point_exp_table_taylor_top.sv =====
// Pipeline: 2 split, 16 Horner and 4 scale stages between input transfer and result.
// Throughput: one item per cycle while i_ready is high; every stage has its own valid bit and a bubble
// is filled while the output is stalled.
// Reset: synchronous active-low i_rst_n clears all stage valid bits; no clearing pass,
// the block is ready in the first cycle after reset is released.
module fixed_point_exp_table_taylor_top
    import fpe_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [31:0] i_x_scaled,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [49:0] o_exp_scaled
);

    t_split w_sp;
    t_poly  w_po;
    logic   w_sp_valid;
    logic   w_sp_ready;
    logic   w_po_valid;
    logic   w_po_ready;

    fpe_split u_split (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_x     (i_x_scaled),
        .o_valid (w_sp_valid),
        .i_ready (w_sp_ready),
        .o_data  (w_sp)
    );

    fpe_horner u_horner (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_sp_valid),
        .o_ready (w_sp_ready),
        .i_data  (w_sp),
        .o_valid (w_po_valid),
        .i_ready (w_po_ready),
        .o_data  (w_po)
    );

    fpe_scale u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_po_valid),
        .o_ready (w_po_ready),
        .i_data  (w_po),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_exp   (o_exp_scaled)
    );

    // input side only backs up when every stage holds an item and the sink stalls
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> (o_valid && !i_ready))
        else $error("input stalled with room in the pipeline");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

endmodule

// ===== dv/tb_fixed_point_exp_table_taylor_top.sv =====
module tb_fixed_point_exp_table_taylor_top;

    localparam int unsigned   K_SCALE     = 10000;
    localparam int unsigned   MAX_INT     = 24;
    localparam int unsigned   FINAL_DIV   = 9999;
    localparam int unsigned   X_SAT       = (MAX_INT + 1) * K_SCALE;
    localparam int            CYCLE_LIMIT = 200000;
    localparam int            DRAIN_WAIT  = 40;
    localparam int            NUM_RANDOM  = 600;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [31:0] i_x_scaled;
    logic        o_valid;
    logic        i_ready;
    logic [49:0] o_exp_scaled;

    logic [49:0] exp_pending[$];
    int          err_count;
    int          cycle_count;
    int          sink_hold;
    bit          idling;

    fixed_point_exp_table_taylor_top uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_x_scaled   (i_x_scaled),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_exp_scaled (o_exp_scaled)
    );

    // round(e^n * 10000) for n = 0..24
    function automatic bit [63:0] e_pow_int(input int unsigned n);
        case (n)
            0:  return 64'd10000;
            1:  return 64'd27183;
            2:  return 64'd73891;
            3:  return 64'd200855;
            4:  return 64'd545982;
            5:  return 64'd1484132;
            6:  return 64'd4034288;
            7:  return 64'd10966332;
            8:  return 64'd29809580;
            9:  return 64'd81030839;
            10: return 64'd220264658;
            11: return 64'd598741417;
            12: return 64'd1627547914;
            13: return 64'd4424133920;
            14: return 64'd12026042842;
            15: return 64'd32690173725;
            16: return 64'd88861105205;
            17: return 64'd241549527536;
            18: return 64'd656599691373;
            19: return 64'd1784823009632;
            20: return 64'd4851651954098;
            21: return 64'd13188157344832;
            22: return 64'd35849128461316;
            23: return 64'd97448034462489;
            default: return 64'd264891221298435;
        endcase
    endfunction

    function automatic logic [49:0] predict_exp(input logic [31:0] x);
        bit [63:0] n;
        bit [63:0] r;
        bit [63:0] a;
        n = 64'(x) / K_SCALE;
        r = 64'(x) % K_SCALE;
        if (n > MAX_INT) begin
            return 50'(e_pow_int(MAX_INT));
        end
        // nested Horner with floor division at every step
        a = K_SCALE + (r * K_SCALE) / 64'd6 / K_SCALE;
        for (int i = 5; i >= 2; i--) begin
            a = K_SCALE + (r * a) / 64'(i) / K_SCALE;
        end
        a = K_SCALE + (r * a) / K_SCALE;
        return 50'((e_pow_int(int'(n)) * a) / FINAL_DIV);
    endfunction

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int p;
        p = $urandom_range(0, 99);
        if (p < 50) begin
            return 0;
        end else if (p < 85) begin
            return $urandom_range(1, 3);
        end else if (p < 97) begin
            return $urandom_range(4, 10);
        end else begin
            return $urandom_range(20, 60);
        end
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // result side: random back-pressure
    initial begin
        i_ready   = 1'b0;
        sink_hold = 0;
        forever begin
            @(posedge i_clk);
            if (sink_hold > 0) begin
                sink_hold = sink_hold - 1;
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
                if (idling && $urandom_range(0, 4) == 0) begin
                    sink_hold = pick_gap();
                end
            end
        end
    end

    always @(posedge i_clk) begin
        logic [49:0] want;
        if (i_rst_n && o_valid && i_ready) begin
            if (exp_pending.size() == 0) begin
                $display("%0t: unexpected result transfer, actual %0d", $time, o_exp_scaled);
                err_count = err_count + 1;
            end else begin
                want = exp_pending.pop_front();
                if (o_exp_scaled !== want) begin
                    $display("%0t: exp_scaled mismatch, expected %0d, actual %0d",
                             $time, want, o_exp_scaled);
                    err_count = err_count + 1;
                end
            end
        end
    end

    task automatic send_exponent(input logic [31:0] x);
        int gap;
        i_valid    <= 1'b1;
        i_x_scaled <= x;
        @(posedge i_clk);
        while (!o_ready) begin
            @(posedge i_clk);
        end
        exp_pending.push_back(predict_exp(x));
        gap = idling ? pick_gap() : 0;
        if (gap > 0) begin
            i_valid    <= 1'b0;
            i_x_scaled <= $urandom;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // integer part 0..24, fraction at both ends
    task automatic test_table_edges();
        idling = 1'b0;
        send_exponent(32'd0);
        send_exponent(32'd1);
        send_exponent(32'd9999);
        send_exponent(32'd10000);
        send_exponent(32'd10001);
        send_exponent(32'd19999);
        send_exponent(32'd20000);
        send_exponent(32'd125000);
        send_exponent(32'd229999);
        send_exponent(32'd239999);
        send_exponent(32'd240000);
        send_exponent(32'd245000);
        send_exponent(X_SAT - 1);
    endtask

    // integer part above the table saturates
    task automatic test_saturation();
        idling = 1'b0;
        send_exponent(X_SAT);
        send_exponent(X_SAT + 1);
        send_exponent(32'd259999);
        send_exponent(32'd1000000);
        send_exponent(32'h7FFF_FFFF);
        send_exponent(32'h8000_0000);
        send_exponent(32'hAAAA_AAAA);
        send_exponent(32'h5555_5555);
        send_exponent(32'hFFFF_FFFF);
    endtask

    task automatic test_random_stream();
        logic [31:0] x;
        int          sel;
        for (int k = 0; k < NUM_RANDOM; k++) begin
            // stretches of 50 items, every third one (starting with the first) without idling
            if (k % 50 == 0) begin
                idling = ((k / 50) % 3) != 0;
            end
            sel = $urandom_range(0, 19);
            if (sel < 11) begin
                x = $urandom_range(0, X_SAT - 1);
            end else if (sel < 14) begin
                x = $urandom_range(0, MAX_INT) * K_SCALE;
                case ($urandom_range(0, 3))
                    0: x = x + 1;
                    1: x = x + K_SCALE - 2;
                    2: x = x + K_SCALE - 1;
                    default: x = x;
                endcase
            end else if (sel < 16) begin
                x = $urandom_range(X_SAT - 10000, X_SAT + 10000);
            end else begin
                x = $urandom;
            end
            send_exponent(x);
        end
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_x_scaled  = 32'd0;
        err_count   = 0;
        cycle_count = 0;
        idling      = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_table_edges();
        test_saturation();
        test_random_stream();

        i_valid <= 1'b0;
        while (exp_pending.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (err_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// ===== fixed_point_exp_table_taylor_top.f =====
rtl/fpe_pkg.sv
rtl/fpe_split.sv
rtl/fpe_horner.sv
rtl/fpe_scale.sv
rtl/fixed_point_exp_table_taylor_top.sv
dv/tb_fixed_point_exp_table_taylor_top.sv
